/* hdl/pst_pkg.sv */
// Shared types, codes and helpers for the pixel store with vertical trace.
package pst_pkg;

  // Command codes as they arrive on the input channel.
  typedef enum logic [2:0] {
    OP_PUT       = 3'd0,
    OP_PLOT      = 3'd1,
    OP_PLOT_RST  = 3'd2,
    OP_GET       = 3'd3,
    OP_CLEAR     = 3'd4
  } op_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Command class after decode; unused opcodes become K_NOP.
  typedef enum logic [2:0] {
    K_PUT,
    K_PLOT,
    K_PLOT_RST,
    K_GET,
    K_CLEAR,
    K_NOP
  } kind_t;

  // Depth of the command queue between front and back (a power of two).
  localparam int QDEPTH = 2;

  // Width of the size operands used in bounds checks.
  localparam int SZW = 13;

  // Reset value of both size registers.
  localparam logic [8:0] SIZE_RST = 9'd256;

  // Active image size as written through the configuration port.
  typedef struct packed {
    logic [8:0] width;
    logic [8:0] height;
  } dims_t;

  // One decoded command as held in the queue.
  typedef struct packed {
    kind_t              kind;
    logic               hit;
    logic signed [9:0]  line;
    logic signed [9:0]  column;
    logic [23:0]        rgb;
  } cmd_t;

  // Queue occupancy flags seen by the front and the back.
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // True when (l, c) lies inside the active image, clipped to the store size.
  function automatic logic in_image(
    input logic signed [9:0] l,
    input logic signed [9:0] c,
    input dims_t             dims,
    input logic [SZW-1:0]    max_w,
    input logic [SZW-1:0]    max_h
  );
    logic [SZW-1:0] lu;
    logic [SZW-1:0] cu;
    lu = {4'd0, l[8:0]};
    cu = {4'd0, c[8:0]};
    return !l[9] && !c[9] &&
           (lu < {4'd0, dims.height}) && (lu < max_h) &&
           (cu < {4'd0, dims.width}) && (cu < max_w);
  endfunction

endpackage

/* hdl/pst_front.sv */
// Front end: configuration registers, command decode and bounds check.
module pst_front
  import pst_pkg::*;
#(
  parameter logic [SZW-1:0] MAX_W = 13'd256,
  parameter logic [SZW-1:0] MAX_H = 13'd256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        in_opcode,
  input  logic signed [9:0] in_line,
  input  logic signed [9:0] in_column,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  qstat_t            qstat,
  output logic              push,
  output cmd_t              push_cmd,
  output dims_t             dims
);

  logic [8:0] width_r;
  logic [8:0] height_r;
  kind_t      kind;
  logic       hit;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_RST;
      height_r <= SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign dims.width  = width_r;
  assign dims.height = height_r;

  // Decode the opcode into a command class.
  always_comb begin
    unique case (in_opcode)
      OP_PUT:      kind = K_PUT;
      OP_PLOT:     kind = K_PLOT;
      OP_PLOT_RST: kind = K_PLOT_RST;
      OP_GET:      kind = K_GET;
      OP_CLEAR:    kind = K_CLEAR;
      default:     kind = K_NOP;
    endcase
  end

  // Only put, plot and get report whether the pixel is inside.
  assign hit = in_image(in_line, in_column, dims, MAX_W, MAX_H) &&
               (kind == K_PUT || kind == K_PLOT || kind == K_GET);

  // A transaction enters the queue whenever there is room.
  assign push            = start && !qstat.full;
  assign push_cmd.kind   = kind;
  assign push_cmd.hit    = hit;
  assign push_cmd.line   = in_line;
  assign push_cmd.column = in_column;
  assign push_cmd.rgb    = {in_red, in_green, in_blue};

endmodule

/* hdl/pst_queue.sv */
// Short command queue between the front end and the back end.
module pst_queue
  import pst_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output cmd_t   head,
  output qstat_t qstat
);

  localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t           data_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QPW:0]   count_r;

  assign qstat.empty = (count_r == '0);
  assign qstat.full  = (count_r == (QPW+1)'(QDEPTH));
  assign head        = data_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) data_r[wr_ptr_r] <= push_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.empty |-> !pop) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPW+1)'(QDEPTH)) else $error("queue count out of range");

endmodule

/* hdl/pst_back.sv */
// Back end: pixel memory, trace and clear sequencer, result register.
module pst_back
  import pst_pkg::*;
#(
  parameter int             MAX_WIDTH  = 256,
  parameter int             MAX_HEIGHT = 256,
  parameter logic [SZW-1:0] MAX_W      = 13'd256,
  parameter logic [SZW-1:0] MAX_H      = 13'd256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dims_t      dims,
  input  qstat_t     qstat,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  output logic [7:0] out_read_red,
  output logic [7:0] out_read_green,
  output logic [7:0] out_read_blue,
  output logic       out_inside_res
);

  localparam int CB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW    = CB + LB;
  localparam int DEPTH = MAX_HEIGHT * (1 << CB);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TRACE,
    S_CLEAR
  } state_t;

  state_t            state_r;
  logic signed [9:0] last_line_r;
  logic signed [9:0] last_column_r;
  logic signed [9:0] trace_line_r;
  logic signed [9:0] trace_col_r;
  logic signed [9:0] tgt_line_r;
  logic [23:0]       color_r;
  logic [AW-1:0]     clr_addr_r;
  logic              res_valid_r;
  logic              res_get_r;
  logic              res_inside_r;
  logic [23:0]       rd_q_r;
  logic [23:0]       mem [DEPTH];

  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [23:0]       mem_wdata;
  logic [AW-1:0]     head_addr;
  logic [AW-1:0]     trace_addr;
  logic              trace_in;
  logic signed [9:0] trace_step;

  // Line and column indexes packed into one memory address.
  function automatic logic [AW-1:0] addr_of(
    input logic signed [9:0] l,
    input logic signed [9:0] c
  );
    logic [SZW-1:0] lu;
    logic [SZW-1:0] cu;
    lu = {3'd0, l};
    cu = {3'd0, c};
    return {lu[LB-1:0], cu[CB-1:0]};
  endfunction

  assign pop        = (state_r == S_IDLE) && !qstat.empty;
  assign head_addr  = addr_of(head.line, head.column);
  assign trace_addr = addr_of(trace_line_r, trace_col_r);
  assign trace_in   = in_image(trace_line_r, trace_col_r, dims, MAX_W, MAX_H);
  assign trace_step = (trace_line_r < tgt_line_r) ? trace_line_r + 10'sd1
                                                  : trace_line_r - 10'sd1;

  // Memory port control for each phase.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = head_addr;
    mem_wdata = head.rgb;
    unique case (state_r)
      S_IDLE: begin
        if (pop && head.hit && (head.kind == K_PUT || head.kind == K_PLOT)) begin
          mem_we = 1'b1;
        end
        if (pop && head.hit && head.kind == K_GET) begin
          mem_re = 1'b1;
        end
      end
      S_TRACE: begin
        mem_we    = trace_in;
        mem_waddr = trace_addr;
        mem_wdata = color_r;
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = color_r;
      end
      default: ;
    endcase
  end

  // Pixel memory with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q_r <= mem[head_addr];
  end

  // Sequencer, remembered plot point and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      res_valid_r   <= 1'b0;
      last_line_r   <= '1;
      last_column_r <= '1;
    end else begin
      res_valid_r <= pop;
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            res_inside_r <= head.hit;
            res_get_r    <= head.hit && (head.kind == K_GET);
            unique case (head.kind)
              K_PLOT: begin
                last_line_r   <= head.line;
                last_column_r <= head.column;
                // Walk from the earlier line when one is remembered.
                if (!last_line_r[9] && last_line_r != head.line) begin
                  state_r      <= S_TRACE;
                  trace_line_r <= last_line_r;
                  trace_col_r  <= last_column_r;
                  tgt_line_r   <= head.line;
                  color_r      <= head.rgb;
                end
              end
              K_PLOT_RST: begin
                last_line_r   <= '1;
                last_column_r <= '1;
              end
              K_CLEAR: begin
                state_r    <= S_CLEAR;
                clr_addr_r <= '0;
                color_r    <= head.rgb;
              end
              default: ;
            endcase
          end
        end
        S_TRACE: begin
          trace_line_r <= trace_step;
          if (trace_step == tgt_line_r) state_r <= S_IDLE;
        end
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(DEPTH - 1)) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result ports; colors are black unless a get hit the image.
  assign out_valid      = res_valid_r;
  assign out_inside_res = res_inside_r;
  assign out_read_red   = res_get_r ? rd_q_r[23:16] : 8'd0;
  assign out_read_green = res_get_r ? rd_q_r[15:8]  : 8'd0;
  assign out_read_blue  = res_get_r ? rd_q_r[7:0]   : 8'd0;

  a_trace_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TRACE |-> trace_line_r != tgt_line_r)
    else $error("trace walking on its target line");
  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> res_valid_r && res_get_r)
    else $error("memory read without a get result");
  a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |=> !res_valid_r)
    else $error("result issued during a walk or clear");

endmodule

/* hdl/pixel_store_with_vertical_trace.sv */
// Top level of the pixel store with vertical trace.
//
// Commands enter on the in_ ports and are accepted at a clock edge where
// start is high and busy is low; busy is high only while the command queue
// is full. Every command gives exactly one result on the out_ ports, shown
// for a single cycle with out_valid high; the receiver cannot stall it.
// The size registers are written on the cfg_ port (index 0 width, index 1
// height), which is always ready; write them only while the block is idle.
// Put, get, plot reset and unused codes leave the back end idle, so they
// sustain one transaction per cycle while no walk or clear holds the queue.
// Plot writes its point, then walks the remembered column from the
// remembered line toward the new line, stopping short of it. Clear writes
// all MAX_HEIGHT * 2**clog2(MAX_WIDTH) memory entries through the single
// write port. Reset restores the sizes to 256 and forgets the remembered
// plot point; pixel memory contents are undefined until written or cleared.
module pixel_store_with_vertical_trace
  import pst_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_opcode,
  input  logic signed [9:0] in_line,
  input  logic signed [9:0] in_column,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  output logic              out_valid,
  output logic [7:0]        out_read_red,
  output logic [7:0]        out_read_green,
  output logic [7:0]        out_read_blue,
  output logic              out_inside_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [8:0]        cfg_data
);

  localparam logic [SZW-1:0] MAX_W = SZW'(MAX_WIDTH);
  localparam logic [SZW-1:0] MAX_H = SZW'(MAX_HEIGHT);

  qstat_t qstat;
  logic   push;
  logic   pop;
  cmd_t   push_cmd;
  cmd_t   head;
  dims_t  dims;

  assign busy = qstat.full;

  pst_front #(
    .MAX_W(MAX_W),
    .MAX_H(MAX_H)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_opcode(in_opcode),
    .in_line  (in_line),
    .in_column(in_column),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .qstat    (qstat),
    .push     (push),
    .push_cmd (push_cmd),
    .dims     (dims)
  );

  pst_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .qstat   (qstat)
  );

  pst_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_W     (MAX_W),
    .MAX_H     (MAX_H)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .dims          (dims),
    .qstat         (qstat),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_read_red  (out_read_red),
    .out_read_green(out_read_green),
    .out_read_blue (out_read_blue),
    .out_inside_res(out_inside_res)
  );

endmodule

/* tb/sv/pixel_store_checker.sv */
// Checker that predicts and compares every result of the pixel store with vertical trace.
module pixel_store_checker
  import pst_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [2:0]        in_opcode,
  input  logic signed [9:0] in_line,
  input  logic signed [9:0] in_column,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  input  logic              out_valid,
  input  logic [7:0]        out_read_red,
  input  logic [7:0]        out_read_green,
  input  logic [7:0]        out_read_blue,
  input  logic              out_inside_res,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  output int                mismatches,
  output int                outstanding
);

  // One predicted result: the color read back and the inside flag.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       hit;
  } pixel_read_t;

  // Shadow copy of the pixel memory, the size registers and the plot anchor.
  logic [23:0] frame [MAX_WIDTH*MAX_HEIGHT];
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  int          anchor_line;
  int          anchor_column;
  pixel_read_t predicted_reads [$];

  // A coordinate is inside when it lies in the active image clipped to the store.
  function automatic bit on_image(int l, int c);
    int w;
    int h;
    w = (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    return l >= 0 && l < h && c >= 0 && c < w;
  endfunction

  // Writes outside the active image are dropped.
  function automatic void paint(int l, int c, logic [23:0] rgb);
    if (on_image(l, c)) frame[l*MAX_WIDTH + c] = rgb;
  endfunction

  // Applies one command to the shadow state and returns the result it gives.
  function automatic pixel_read_t execute_command(logic [2:0] op, int l, int c,
                                                  logic [23:0] rgb);
    pixel_read_t res;
    res = '0;
    case (op)
      OP_PUT: begin
        res.hit = on_image(l, c);
        paint(l, c, rgb);
      end
      OP_PLOT: begin
        res.hit = on_image(l, c);
        paint(l, c, rgb);
        // Walk the old column from the anchor line toward the new line,
        // stopping short of the new line itself.
        if (anchor_line >= 0) begin
          while (anchor_line != l) begin
            paint(anchor_line, anchor_column, rgb);
            anchor_line += (anchor_line < l) ? 1 : -1;
          end
        end
        anchor_line   = l;
        anchor_column = c;
      end
      OP_PLOT_RST: begin
        anchor_line   = -1;
        anchor_column = -1;
      end
      OP_GET: begin
        if (on_image(l, c)) begin
          res.hit = 1'b1;
          {res.red, res.green, res.blue} = frame[l*MAX_WIDTH + c];
        end
      end
      OP_CLEAR: begin
        foreach (frame[k]) frame[k] = rgb;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Track configuration writes, check results in order, and predict new ones.
  always @(posedge clk) begin
    pixel_read_t want;
    if (!rst_n) begin
      width_reg     = SIZE_RST;
      height_reg    = SIZE_RST;
      anchor_line   = -1;
      anchor_column = -1;
      predicted_reads.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_WIDTH:  width_reg  = cfg_data;
          REG_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (predicted_reads.size() == 0) begin
          $error("result transaction with no command outstanding");
          mismatches++;
        end else begin
          want = predicted_reads.pop_front();
          if (out_read_red !== want.red) begin
            $error("read_red: expected %0d, actual %0d", want.red, out_read_red);
            mismatches++;
          end
          if (out_read_green !== want.green) begin
            $error("read_green: expected %0d, actual %0d", want.green, out_read_green);
            mismatches++;
          end
          if (out_read_blue !== want.blue) begin
            $error("read_blue: expected %0d, actual %0d", want.blue, out_read_blue);
            mismatches++;
          end
          if (out_inside_res !== want.hit) begin
            $error("inside_res: expected %0d, actual %0d", want.hit, out_inside_res);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        predicted_reads.push_back(execute_command(in_opcode, int'(in_line),
                                                  int'(in_column),
                                                  {in_red, in_green, in_blue}));
      end
    end
    outstanding = predicted_reads.size();
  end

endmodule

/* tb/sv/pixel_store_with_vertical_trace_test.sv */
// Testbench top for the pixel store with vertical trace: stimulus, watchdog and verdict.
module pixel_store_with_vertical_trace_test;
  import pst_pkg::*;

  localparam int MAX_W          = 256;
  localparam int MAX_H          = 256;
  localparam int QUIET_LIMIT    = 300000;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int PHASE_COUNT    = 6;
  localparam int RECENT_DEPTH   = 32;
  // A trace may still walk up to 1023 lines after its plot result is out.
  localparam int SETTLE_CYCLES  = 1100;
  localparam int DRAIN_CYCLES   = 10;

  // Opcodes that the block decodes as no operation.
  localparam logic [2:0] SPARE_OP_LO  = 3'd5;
  localparam logic [2:0] SPARE_OP_MID = 3'd6;
  localparam logic [2:0] SPARE_OP_HI  = 3'd7;

  typedef struct {
    int l;
    int c;
  } spot_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [2:0]        in_opcode;
  logic signed [9:0] in_line;
  logic signed [9:0] in_column;
  logic [7:0]        in_red;
  logic [7:0]        in_green;
  logic [7:0]        in_blue;
  logic              out_valid;
  logic [7:0]        out_read_red;
  logic [7:0]        out_read_green;
  logic [7:0]        out_read_blue;
  logic              out_inside_res;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [0:0]        cfg_index;
  logic [8:0]        cfg_data;
  int                mismatches;
  int                outstanding;

  // Stimulus-side view of the image size and the last plot point.
  int    idle_pct;
  int    img_w;
  int    img_h;
  int    trail_line;
  int    trail_col;
  spot_t recent_spots [$];

  pixel_store_with_vertical_trace #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_line        (in_line),
    .in_column      (in_column),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_read_red   (out_read_red),
    .out_read_green (out_read_green),
    .out_read_blue  (out_read_blue),
    .out_inside_res (out_inside_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  pixel_store_checker #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_line        (in_line),
    .in_column      (in_column),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_read_red   (out_read_red),
    .out_read_green (out_read_green),
    .out_read_blue  (out_read_blue),
    .out_inside_res (out_inside_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ends the run when no transaction of any kind happens for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Keeps a short history of written coordinates so that gets hit them.
  function automatic void remember(int l, int c);
    spot_t s;
    s.l = l;
    s.c = c;
    recent_spots.push_back(s);
    if (recent_spots.size() > RECENT_DEPTH) void'(recent_spots.pop_front());
  endfunction

  // Mostly inside the image, some on its borders, the rest anywhere in range.
  function automatic int pick_coord(int extent);
    int                roll;
    logic signed [9:0] raw;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(0, extent - 1);
    if (roll < 88) begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return extent - 1;
        2: return extent;
        default: return -1;
      endcase
    end
    raw = 10'($urandom);
    return raw;
  endfunction

  // Sends one command transaction, with random idle cycles in front of it.
  task automatic issue(input logic [2:0] opcode, input int l, input int c,
                       input logic [23:0] rgb);
    case (opcode)
      OP_PUT: remember(l, c);
      OP_PLOT: begin
        remember(l, c);
        if (trail_line >= 0 && l >= 0 && trail_line != l)
          remember((trail_line < l) ? $urandom_range(trail_line, l - 1)
                                    : $urandom_range(l + 1, trail_line), trail_col);
        trail_line = l;
        trail_col  = c;
      end
      OP_PLOT_RST: trail_line = -1;
      default: ;
    endcase
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    in_opcode <= opcode;
    in_line   <= l[9:0];
    in_column <= c[9:0];
    {in_red, in_green, in_blue} <= rgb;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Writes both size registers once every result is back and the block is quiet.
  task automatic set_image(input int w, input int h);
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= w[8:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h[8:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    img_w = (w > MAX_W) ? MAX_W : w;
    img_h = (h > MAX_H) ? MAX_H : h;
  endtask

  // Random mix weighted toward puts, plots and gets of recently written pixels.
  task automatic run_random(input int count);
    int    roll;
    spot_t s;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 999);
      if (roll < 2) begin
        issue(OP_CLEAR, pick_coord(img_h), pick_coord(img_w), 24'($urandom));
      end else if (roll < 300) begin
        issue(OP_PUT, pick_coord(img_h), pick_coord(img_w), 24'($urandom));
      end else if (roll < 550) begin
        issue(OP_PLOT, pick_coord(img_h), pick_coord(img_w), 24'($urandom));
      end else if (roll < 600) begin
        issue(OP_PLOT_RST, pick_coord(img_h), pick_coord(img_w), 24'($urandom));
      end else if (roll < 640) begin
        issue(3'($urandom_range(SPARE_OP_LO, SPARE_OP_HI)), pick_coord(img_h),
              pick_coord(img_w), 24'($urandom));
      end else if (recent_spots.size() != 0 && $urandom_range(0, 1)) begin
        s = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
        issue(OP_GET, s.l, s.c, 24'($urandom));
      end else begin
        issue(OP_GET, pick_coord(img_h), pick_coord(img_w), 24'($urandom));
      end
    end
  endtask

  initial begin
    start      = 1'b0;
    in_opcode  = OP_PUT;
    in_line    = '0;
    in_column  = '0;
    in_red     = '0;
    in_green   = '0;
    in_blue    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_WIDTH;
    cfg_data   = '0;
    rst_n      = 1'b0;
    idle_pct   = 0;
    img_w      = MAX_W;
    img_h      = MAX_H;
    trail_line = -1;
    trail_col  = -1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Clear first so that no get ever reads an unwritten pixel.
    issue(OP_CLEAR, 0, 0, 24'hFF00A5);
    issue(OP_GET, 0, 0, 24'h000000);
    issue(OP_PUT, 0, 0, 24'h000000);
    issue(OP_PUT, 255, 255, 24'hFFFFFF);
    issue(OP_GET, 0, 0, 24'hFFFFFF);
    issue(OP_GET, 255, 255, 24'h000000);
    // Writes outside the image are dropped and gets there answer black.
    issue(OP_PUT, -1, 5, 24'h123456);
    issue(OP_PUT, 256, 0, 24'h123456);
    issue(OP_PUT, 511, -512, 24'h123456);
    issue(OP_GET, -512, 511, 24'h000000);
    issue(OP_GET, 256, 10, 24'h000000);
    // First plot after reset draws no trace; the second walks down four lines.
    issue(OP_PLOT, 10, 20, 24'h112233);
    issue(OP_PLOT, 14, 30, 24'h445566);
    issue(OP_GET, 12, 20, 24'h000000);
    issue(OP_GET, 14, 30, 24'h000000);
    // The new point is off the image, so the following trace column is skipped.
    issue(OP_PLOT, 5, 300, 24'h778899);
    issue(OP_PLOT, 8, 40, 24'hAABBCC);
    // A plot on a negative line leaves no anchor for the next plot.
    issue(OP_PLOT, -3, 7, 24'hDDEEFF);
    issue(OP_PLOT, 20, 7, 24'h0F0F0F);
    issue(OP_PLOT_RST, 0, 0, 24'h000000);
    issue(OP_PLOT, 30, 1, 24'hF0F0F0);
    issue(OP_PLOT, 30, 50, 24'h5A5A5A);
    issue(OP_GET, 9, 40, 24'h000000);
    issue(SPARE_OP_LO, 3, 3, 24'hFFFFFF);
    issue(SPARE_OP_MID, -1, -1, 24'hFFFFFF);
    issue(SPARE_OP_HI, 511, 511, 24'hFFFFFF);

    // Random phases over several image sizes and sender idle rates.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: begin
          set_image(1, 1);
          idle_pct = 86;
        end
        2: begin
          set_image(256, 1);
          idle_pct = 37;
        end
        3: begin
          set_image(1, 256);
          idle_pct = 0;
        end
        4: begin
          set_image($urandom_range(2, 255), $urandom_range(2, 255));
          idle_pct = 86;
        end
        default: begin
          set_image(256, 256);
          idle_pct = 37;
        end
      endcase
      run_random(ITEMS_PER_PHASE);
    end

    // Drain every outstanding result, then give the block a few more cycles.
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
hdl/pst_pkg.sv
hdl/pst_front.sv
hdl/pst_queue.sv
hdl/pst_back.sv
hdl/pixel_store_with_vertical_trace.sv
tb/sv/pixel_store_checker.sv
tb/sv/pixel_store_with_vertical_trace_test.sv
